// ===== design/kcl_pkg.sv =====
`default_nettype none
package kcl_pkg;

  localparam int KEY_W    = 5;
  localparam int CHAR_W   = 8;
  localparam int COL_W    = 3;
  localparam int OUTC_W   = 2;
  localparam int MASTER_W = 40;
  localparam int CODE_W   = 32;
  localparam int FAIL_W   = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] CH_STAR = 8'd42;
  localparam logic [CHAR_W-1:0] CH_HASH = 8'd35;
  localparam logic [FAIL_W-1:0] FAIL_SAT = 4'd15;

  // Register reset values.
  localparam logic [MASTER_W-1:0] MASTER_RST   = 40'h3132333435;
  localparam logic [CODE_W-1:0]   USER_RST     = 32'hFFFF_FFFF;
  localparam logic [FAIL_W-1:0]   MAX_FAIL_RST = 4'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MASTER   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USER     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FAIL = 2'd2;

  // Outcome codes.
  localparam logic [OUTC_W-1:0] OUT_NONE  = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_OPEN  = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_WRONG = 2'd2;
  localparam logic [OUTC_W-1:0] OUT_NEW   = 2'd3;

  typedef struct packed {
    logic [MASTER_W-1:0] master_code;
    logic [CODE_W-1:0]   user_code;
    logic [FAIL_W-1:0]   max_failures;
    logic                load_code;
  } cfg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] echo_char;
    logic [COL_W-1:0]  echo_column;
    logic [OUTC_W-1:0] outcome;
    logic [CODE_W-1:0] new_code;
    logic [FAIL_W-1:0] fail_total;
    logic              locked;
  } result_t;

  // Map a row-major keypad scan code to ASCII; unmapped codes pass raw.
  function automatic logic [CHAR_W-1:0] key_to_char(input logic [KEY_W-1:0] code);
    logic [CHAR_W-1:0] c;
    c = {{(CHAR_W-KEY_W){1'b0}}, code};
    case (code)
      5'd1:    c = 8'd49;
      5'd2:    c = 8'd50;
      5'd3:    c = 8'd51;
      5'd5:    c = 8'd52;
      5'd6:    c = 8'd53;
      5'd7:    c = 8'd54;
      5'd9:    c = 8'd55;
      5'd10:   c = 8'd56;
      5'd11:   c = 8'd57;
      5'd13:   c = CH_STAR;
      5'd14:   c = 8'd48;
      5'd15:   c = CH_HASH;
      default: c = {{(CHAR_W-KEY_W){1'b0}}, code};
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/kcl_ctrl.sv =====
`default_nettype none
module kcl_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          step,
  input  wire [kcl_pkg::KEY_W-1:0]     key_code,
  input  wire kcl_pkg::cfg_t           cfg,
  output kcl_pkg::result_t             res
);

  typedef enum logic [1:0] {
    PH_STAR,
    PH_ENTRY,
    PH_HASH,
    PH_NEW
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [2:0]                      key_index_r, key_index_nxt;
  logic [kcl_pkg::CHAR_W-1:0]      buf_r [5];
  logic [kcl_pkg::CHAR_W-1:0]      buf_nxt [5];
  logic [kcl_pkg::CODE_W-1:0]      stored_code_r, stored_code_nxt;
  logic [kcl_pkg::FAIL_W-1:0]      fail_r, fail_nxt;

  logic [kcl_pkg::CHAR_W-1:0]      ch;
  logic [2:0]                      k4, k3;
  logic                            master_hit, user_hit;
  logic [kcl_pkg::COL_W-1:0]       column;
  logic [kcl_pkg::OUTC_W-1:0]      outcome;

  assign ch = kcl_pkg::key_to_char(key_code);
  assign k4 = (key_index_r > 3'd4) ? 3'd4 : key_index_r;
  assign k3 = (key_index_r > 3'd3) ? 3'd3 : key_index_r;

  // The fifth key is compared as it arrives, the first four from the buffer.
  assign master_hit = (buf_r[0] == cfg.master_code[39:32]) &&
                      (buf_r[1] == cfg.master_code[31:24]) &&
                      (buf_r[2] == cfg.master_code[23:16]) &&
                      (buf_r[3] == cfg.master_code[15:8])  &&
                      (ch       == cfg.master_code[7:0]);
  assign user_hit   = (buf_r[0] == stored_code_r[31:24]) &&
                      (buf_r[1] == stored_code_r[23:16]) &&
                      (buf_r[2] == stored_code_r[15:8])  &&
                      (buf_r[3] == stored_code_r[7:0])   &&
                      (ch       == kcl_pkg::CH_HASH);

  always_comb begin
    phase_nxt       = phase_r;
    key_index_nxt   = key_index_r;
    stored_code_nxt = stored_code_r;
    fail_nxt        = fail_r;
    for (int i = 0; i < 5; i++) buf_nxt[i] = buf_r[i];
    column  = 3'd1;
    outcome = kcl_pkg::OUT_NONE;
    unique case (phase_r)
      PH_STAR: begin
        buf_nxt[0] = ch;
        if (ch == kcl_pkg::CH_STAR) begin
          phase_nxt     = PH_ENTRY;
          key_index_nxt = 3'd0;
        end
      end
      PH_ENTRY: begin
        buf_nxt[k4] = ch;
        column = k4 + 3'd1;
        if (k4 < 3'd4) begin
          key_index_nxt = k4 + 3'd1;
        end else if (master_hit) begin
          phase_nxt = PH_HASH;
        end else begin
          if ((fail_r < cfg.max_failures) && user_hit) begin
            outcome = kcl_pkg::OUT_OPEN;
          end else begin
            outcome = kcl_pkg::OUT_WRONG;
            if (fail_r < kcl_pkg::FAIL_SAT) fail_nxt = fail_r + 4'd1;
          end
          phase_nxt     = PH_STAR;
          key_index_nxt = 3'd0;
        end
      end
      PH_HASH: begin
        column        = 3'd6;
        phase_nxt     = (ch == kcl_pkg::CH_HASH) ? PH_NEW : PH_STAR;
        key_index_nxt = 3'd0;
      end
      PH_NEW: begin
        buf_nxt[k3[1:0]] = ch;
        column = k3 + 3'd1;
        if (k3 < 3'd3) begin
          key_index_nxt = k3 + 3'd1;
        end else begin
          stored_code_nxt = {buf_r[0], buf_r[1], buf_r[2], ch};
          outcome         = kcl_pkg::OUT_NEW;
          phase_nxt       = PH_STAR;
          key_index_nxt   = 3'd0;
        end
      end
      default: begin
        phase_nxt = PH_STAR;
      end
    endcase
  end

  assign res.echo_char   = ch;
  assign res.echo_column = column;
  assign res.outcome     = outcome;
  assign res.new_code    = stored_code_nxt;
  assign res.fail_total  = fail_nxt;
  assign res.locked      = (fail_nxt >= cfg.max_failures);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_STAR;
      key_index_r   <= 3'd0;
      stored_code_r <= kcl_pkg::USER_RST;
      fail_r        <= '0;
    end else if (cfg.load_code) begin
      stored_code_r <= cfg.user_code;
    end else if (step) begin
      phase_r       <= phase_nxt;
      key_index_r   <= key_index_nxt;
      stored_code_r <= stored_code_nxt;
      fail_r        <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 5; i++) buf_r[i] <= buf_nxt[i];
    end
  end

endmodule
`default_nettype wire

// ===== design/keypad_code_lock.sv =====
// Keypad code lock: one key code in, one result out per transfer.
// The key passes an input register, then a result register; throughput: one
// key per cycle while the result is not stalled, set by the combinational
// decode and compare between the two registers. A stalled result holds the
// result register and, once the input register is full, stalls the input.
// Reset (rst_n low, synchronous): session waits for '*', failure count 0,
// registers and stored code return to their defaults.
`default_nettype none
module keypad_code_lock (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [kcl_pkg::KEY_W-1:0]       in_key_code,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [kcl_pkg::CHAR_W-1:0]      out_echo_char,
  output logic [kcl_pkg::COL_W-1:0]       out_echo_column,
  output logic [kcl_pkg::OUTC_W-1:0]      out_outcome,
  output logic [kcl_pkg::CODE_W-1:0]      out_new_code,
  output logic [kcl_pkg::FAIL_W-1:0]      out_fail_total,
  output logic                            out_locked,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [kcl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [kcl_pkg::MASTER_W-1:0]    cfg_data
);

  // Input register stage.
  logic                         in_valid_r;
  logic [kcl_pkg::KEY_W-1:0]    key_r;

  // Result register stage.
  logic                         out_valid_r;
  kcl_pkg::result_t             res_r;
  kcl_pkg::result_t             res;

  // Configuration registers.
  logic [kcl_pkg::MASTER_W-1:0] master_r;
  logic [kcl_pkg::FAIL_W-1:0]   max_fail_r;
  logic                         cfg_wr;
  logic                         load_code;
  kcl_pkg::cfg_t                cfg;

  logic in_take, out_take, advance;

  // Advance the held key into the result register whenever that register is
  // empty or its result transfers this cycle.
  assign out_take = out_valid_r && !out_stall;
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_take)      in_valid_r <= 1'b1;
      else if (advance) in_valid_r <= 1'b0;
      if (advance)       out_valid_r <= 1'b1;
      else if (out_take) out_valid_r <= 1'b0;
    end
  end

  // Payload registers: load on transfer, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) key_r <= in_key_code;
    if (advance) res_r <= res;
  end

  // Configuration writes are always accepted; a user code write goes straight
  // into the stored code, which is the only place that value lives.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign load_code = cfg_wr && (cfg_index == kcl_pkg::REG_USER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r   <= kcl_pkg::MASTER_RST;
      max_fail_r <= kcl_pkg::MAX_FAIL_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        kcl_pkg::REG_MASTER:   master_r   <= cfg_data;
        kcl_pkg::REG_MAX_FAIL: max_fail_r <= cfg_data[kcl_pkg::FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.master_code  = master_r;
  assign cfg.user_code    = cfg_data[kcl_pkg::CODE_W-1:0];
  assign cfg.max_failures = max_fail_r;
  assign cfg.load_code    = load_code;

  // Session state machine and compare logic; state moves on each advance that does not meet a user code write.
  kcl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (advance),
    .key_code (key_r),
    .cfg      (cfg),
    .res      (res)
  );

  assign out_valid       = out_valid_r;
  assign out_echo_char   = res_r.echo_char;
  assign out_echo_column = res_r.echo_column;
  assign out_outcome     = res_r.outcome;
  assign out_new_code    = res_r.new_code;
  assign out_fail_total  = res_r.fail_total;
  assign out_locked      = res_r.locked;

`ifndef SYNTHESIS
  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not filled after advance");

  a_open_unlocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.outcome == kcl_pkg::OUT_OPEN)) |-> !res_r.locked)
    else $error("door opened while locked");

  a_wrong_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.outcome == kcl_pkg::OUT_WRONG)) |-> (res_r.fail_total != '0))
    else $error("wrong code without a failure counted");

  a_fail_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.fail_total == kcl_pkg::FAIL_SAT))
      |=> (!out_valid_r || (res_r.fail_total == kcl_pkg::FAIL_SAT)))
    else $error("saturated failure count dropped");
`endif

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Package widths, codes and types this bench uses.
  localparam int KEY_W     = kcl_pkg::KEY_W;
  localparam int CHAR_W    = kcl_pkg::CHAR_W;
  localparam int COL_W     = kcl_pkg::COL_W;
  localparam int OUTC_W    = kcl_pkg::OUTC_W;
  localparam int MASTER_W  = kcl_pkg::MASTER_W;
  localparam int CODE_W    = kcl_pkg::CODE_W;
  localparam int FAIL_W    = kcl_pkg::FAIL_W;
  localparam int CFG_IDX_W = kcl_pkg::CFG_IDX_W;

  localparam logic [CHAR_W-1:0]    CH_STAR      = kcl_pkg::CH_STAR;
  localparam logic [CHAR_W-1:0]    CH_HASH      = kcl_pkg::CH_HASH;
  localparam logic [FAIL_W-1:0]    FAIL_SAT     = kcl_pkg::FAIL_SAT;
  localparam logic [MASTER_W-1:0]  MASTER_RST   = kcl_pkg::MASTER_RST;
  localparam logic [CODE_W-1:0]    USER_RST     = kcl_pkg::USER_RST;
  localparam logic [FAIL_W-1:0]    MAX_FAIL_RST = kcl_pkg::MAX_FAIL_RST;
  localparam logic [CFG_IDX_W-1:0] REG_MASTER   = kcl_pkg::REG_MASTER;
  localparam logic [CFG_IDX_W-1:0] REG_USER     = kcl_pkg::REG_USER;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FAIL = kcl_pkg::REG_MAX_FAIL;
  localparam logic [OUTC_W-1:0]    OUT_NONE     = kcl_pkg::OUT_NONE;
  localparam logic [OUTC_W-1:0]    OUT_OPEN     = kcl_pkg::OUT_OPEN;
  localparam logic [OUTC_W-1:0]    OUT_WRONG    = kcl_pkg::OUT_WRONG;
  localparam logic [OUTC_W-1:0]    OUT_NEW      = kcl_pkg::OUT_NEW;

  typedef kcl_pkg::result_t result_t;

  // Keypad scan codes the stimulus needs by name.
  localparam logic [KEY_W-1:0] KEY_STAR = 5'd13;
  localparam logic [KEY_W-1:0] KEY_HASH = 5'd15;
  localparam logic [CHAR_W-1:0] CH_ZERO = 8'd48;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int KEYS_PER_PHASE = 475;
  localparam int SHOW_LIMIT = 10;

  typedef enum logic [1:0] {AWAIT_STAR, GET_KEYS, AWAIT_HASH, GET_NEW} lock_phase_t;
  typedef enum {GO_NOISE, GO_MASTER, GO_USER, GO_USER_BAD, GO_RANDOM} session_goal_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    bit               typed;
    result_t          r;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [KEY_W-1:0] in_key_code = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [MASTER_W-1:0] cfg_data = '0;

  wire in_stall;
  wire out_valid;
  wire [CHAR_W-1:0] out_echo_char;
  wire [COL_W-1:0] out_echo_column;
  wire [OUTC_W-1:0] out_outcome;
  wire [CODE_W-1:0] out_new_code;
  wire [FAIL_W-1:0] out_fail_total;
  wire out_locked;
  wire cfg_ready;

  keypad_code_lock i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_key_code     (in_key_code),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_echo_char   (out_echo_char),
    .out_echo_column (out_echo_column),
    .out_outcome     (out_outcome),
    .out_new_code    (out_new_code),
    .out_fail_total  (out_fail_total),
    .out_locked      (out_locked),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Lock state as the testbench tracks it, plus its copy of the registers.
  lock_phase_t         lk_phase = AWAIT_STAR;
  logic [2:0]          lk_index = '0;
  logic [CHAR_W-1:0]   lk_entry [5];
  logic [CODE_W-1:0]   lk_stored = USER_RST;
  logic [FAIL_W-1:0]   lk_fails = '0;
  logic [MASTER_W-1:0] lk_master = MASTER_RST;
  logic [FAIL_W-1:0]   lk_maxf = MAX_FAIL_RST;

  // Results still owed by the block, oldest first.
  result_t lock_replies [$];

  int gap_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;
  int errors = 0;
  int n_keys = 0;
  int n_results = 0;
  int n_open = 0;
  int n_new = 0;
  int n_wrong = 0;
  int n_locked = 0;

  result_t want;
  result_t got;

  // Translate a scan code into the character the lock echoes.
  function automatic logic [CHAR_W-1:0] char_of(input logic [KEY_W-1:0] key);
    case (key)
      5'd1, 5'd2, 5'd3:  return CH_ZERO + 8'(key);
      5'd5, 5'd6, 5'd7:  return CH_ZERO + 8'(key) - 8'd1;
      5'd9, 5'd10, 5'd11: return CH_ZERO + 8'(key) - 8'd2;
      KEY_STAR:          return CH_STAR;
      5'd14:             return CH_ZERO;
      KEY_HASH:          return CH_HASH;
      default:           return {3'b000, key};
    endcase
  endfunction

  // Find the scan code that produces a character; the mapping is one to one.
  function automatic bit key_for(input logic [CHAR_W-1:0] ch, output logic [KEY_W-1:0] key);
    for (int c = 0; c < 32; c++) begin
      if (char_of(c[KEY_W-1:0]) == ch) begin
        key = c[KEY_W-1:0];
        return 1'b1;
      end
    end
    key = '0;
    return 1'b0;
  endfunction

  // Favor the twelve keypad keys, but reach the raw and out-of-range codes too.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(99) < 80) return KEY_W'($urandom_range(15, 1));
    return KEY_W'($urandom_range(31));
  endfunction

  // Build a code of n characters that some key sequence can type.
  function automatic logic [MASTER_W-1:0] typable_code(input int n);
    logic [MASTER_W-1:0] w;
    w = '0;
    for (int i = 0; i < n; i++) w = {w[MASTER_W-CHAR_W-1:0], char_of(pick_key())};
    return w;
  endfunction

  function automatic dir_row_t fixed_row(input logic [KEY_W-1:0] key,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [COL_W-1:0] col,
                                         input logic [OUTC_W-1:0] outc,
                                         input logic [CODE_W-1:0] code,
                                         input logic [FAIL_W-1:0] fails,
                                         input logic lock);
    dir_row_t d;
    d.key = key;
    d.typed = 1'b1;
    d.r.echo_char = ch;
    d.r.echo_column = col;
    d.r.outcome = outc;
    d.r.new_code = code;
    d.r.fail_total = fails;
    d.r.locked = lock;
    return d;
  endfunction

  function automatic dir_row_t pred_row(input logic [KEY_W-1:0] key);
    dir_row_t d;
    d.key = key;
    d.typed = 1'b0;
    d.r = '0;
    return d;
  endfunction

  // Advance the tracked lock by one key and return the result it must give.
  task automatic step_lock(input logic [KEY_W-1:0] key, output result_t r);
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0] col;
    logic [OUTC_W-1:0] outc;
    int k;
    ch = char_of(key);
    col = 3'd1;
    outc = OUT_NONE;
    case (lk_phase)
      AWAIT_STAR: begin
        lk_entry[0] = ch;
        if (ch == CH_STAR) begin
          lk_phase = GET_KEYS;
          lk_index = '0;
        end
      end
      GET_KEYS: begin
        k = (lk_index > 3'd4) ? 4 : int'(lk_index);
        lk_entry[k] = ch;
        col = COL_W'(k + 1);
        if (k < 4) begin
          lk_index = 3'(k + 1);
        end else if ({lk_entry[0], lk_entry[1], lk_entry[2], lk_entry[3], lk_entry[4]}
                     == lk_master) begin
          lk_phase = AWAIT_HASH;
        end else begin
          // User entry opens only below the failure limit; all else is a failure.
          if (lk_fails < lk_maxf &&
              {lk_entry[0], lk_entry[1], lk_entry[2], lk_entry[3]} == lk_stored &&
              lk_entry[4] == CH_HASH) begin
            outc = OUT_OPEN;
          end else begin
            outc = OUT_WRONG;
            if (lk_fails != FAIL_SAT) lk_fails = lk_fails + 4'd1;
          end
          lk_phase = AWAIT_STAR;
          lk_index = '0;
        end
      end
      AWAIT_HASH: begin
        col = 3'd6;
        lk_phase = (ch == CH_HASH) ? GET_NEW : AWAIT_STAR;
        lk_index = '0;
      end
      default: begin
        k = (lk_index > 3'd3) ? 3 : int'(lk_index);
        lk_entry[k] = ch;
        col = COL_W'(k + 1);
        if (k < 3) begin
          lk_index = 3'(k + 1);
        end else begin
          lk_stored = {lk_entry[0], lk_entry[1], lk_entry[2], lk_entry[3]};
          outc = OUT_NEW;
          lk_phase = AWAIT_STAR;
          lk_index = '0;
        end
      end
    endcase
    r.echo_char = ch;
    r.echo_column = col;
    r.outcome = outc;
    r.new_code = lk_stored;
    r.fail_total = lk_fails;
    r.locked = (lk_fails >= lk_maxf);
  endtask

  // Offer one key after a random gap, hold it until the transfer, then log
  // what the lock must answer. A typed row overrides the computed answer.
  task automatic send_key(input logic [KEY_W-1:0] key, input bit typed, input result_t typed_r);
    result_t r;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_code <= key;
    do @(posedge clk); while (in_stall);
    step_lock(key, r);
    if (typed) r = typed_r;
    lock_replies.push_back(r);
    n_keys++;
    if (r.outcome == OUT_OPEN) n_open++;
    if (r.outcome == OUT_NEW) n_new++;
    if (r.outcome == OUT_WRONG) n_wrong++;
    if (r.locked) n_locked++;
  endtask

  // Drop valid and wait until the lock has answered every key sent.
  task automatic drain();
    in_valid <= 1'b0;
    while (lock_replies.size() != 0) @(posedge clk);
  endtask

  // Write all three registers back to back; valid stays high between writes.
  task automatic set_lock_regs(input logic [MASTER_W-1:0] master,
                               input logic [CODE_W-1:0] user,
                               input logic [FAIL_W-1:0] maxf);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [MASTER_W-1:0] val [3];
    idx = '{REG_MASTER, REG_USER, REG_MAX_FAIL};
    // Fill the unused upper data bits with noise; the lock must ignore them.
    val = '{master, {8'($urandom), user}, {36'({$urandom, $urandom}), maxf}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        REG_MASTER: lk_master = val[i];
        REG_USER:   lk_stored = val[i][CODE_W-1:0];
        default:    lk_maxf = val[i][FAIL_W-1:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // Receiver side: stall at the rate the current phase asks.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Compare every result transfer with the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got.echo_char = out_echo_char;
      got.echo_column = out_echo_column;
      got.outcome = out_outcome;
      got.new_code = out_new_code;
      got.fail_total = out_fail_total;
      got.locked = out_locked;
      n_results++;
      if (lock_replies.size() == 0) begin
        errors++;
        if (errors <= SHOW_LIMIT)
          $display("%0t: result with nothing owed: char %h col %0d out %0d code %h %s",
                   $realtime, got.echo_char, got.echo_column, got.outcome, got.new_code,
                   $sformatf("fails %0d lock %b", got.fail_total, got.locked));
      end else begin
        want = lock_replies.pop_front();
        if (got.echo_char !== want.echo_char || got.echo_column !== want.echo_column ||
            got.outcome !== want.outcome || got.new_code !== want.new_code ||
            got.fail_total !== want.fail_total || got.locked !== want.locked) begin
          errors++;
          if (errors <= SHOW_LIMIT) begin
            $display("%0t: mismatch exp char %h col %0d out %0d code %h fails %0d lock %b",
                     $realtime, want.echo_char, want.echo_column, want.outcome,
                     want.new_code, want.fail_total, want.locked);
            $display("            got char %h col %0d out %0d code %h fails %0d lock %b",
                     got.echo_char, got.echo_column, got.outcome, got.new_code,
                     got.fail_total, got.locked);
          end
        end
      end
    end
  end

  // Count cycles without any transfer on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    dir_row_t dir_tab [25];
    session_goal_t goal;
    logic [KEY_W-1:0] key;
    logic [CHAR_W-1:0] want_ch;
    int counted;
    int roll;
    int bad_pos;
    bit found;

    // Directed walk with reset registers: master "12345", user all ones,
    // limit 3. Extremes of the scan code, a master session that sets user
    // code "0789", that code opening the door, then one wrong entry.
    dir_tab = '{
      fixed_row(5'd0,  8'd0,  3'd1, OUT_NONE, USER_RST, 4'd0, 1'b0),
      fixed_row(5'd31, 8'd31, 3'd1, OUT_NONE, USER_RST, 4'd0, 1'b0),
      fixed_row(KEY_STAR, CH_STAR, 3'd1, OUT_NONE, USER_RST, 4'd0, 1'b0),
      fixed_row(5'd1, 8'd49, 3'd1, OUT_NONE, USER_RST, 4'd0, 1'b0),
      fixed_row(5'd2, 8'd50, 3'd2, OUT_NONE, USER_RST, 4'd0, 1'b0),
      fixed_row(5'd3, 8'd51, 3'd3, OUT_NONE, USER_RST, 4'd0, 1'b0),
      fixed_row(5'd5, 8'd52, 3'd4, OUT_NONE, USER_RST, 4'd0, 1'b0),
      fixed_row(5'd6, 8'd53, 3'd5, OUT_NONE, USER_RST, 4'd0, 1'b0),
      fixed_row(KEY_HASH, CH_HASH, 3'd6, OUT_NONE, USER_RST, 4'd0, 1'b0),
      pred_row(5'd14),
      pred_row(5'd9),
      pred_row(5'd10),
      fixed_row(5'd11, 8'd57, 3'd4, OUT_NEW, 32'h3037_3839, 4'd0, 1'b0),
      pred_row(KEY_STAR),
      pred_row(5'd14),
      pred_row(5'd9),
      pred_row(5'd10),
      pred_row(5'd11),
      fixed_row(KEY_HASH, CH_HASH, 3'd5, OUT_OPEN, 32'h3037_3839, 4'd0, 1'b0),
      pred_row(KEY_STAR),
      pred_row(5'd1),
      pred_row(5'd1),
      pred_row(5'd1),
      pred_row(5'd1),
      fixed_row(5'd1, 8'd49, 3'd5, OUT_WRONG, 32'h3037_3839, 4'd1, 1'b0)
    };
    goal = GO_NOISE;

    // Hold reset, then release it for good.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_key(dir_tab[i].key, dir_tab[i].typed, dir_tab[i].r);
    drain();

    for (int p = 0; p < 4; p++) begin
      // Reconfigure only once the lock is idle, and set the pacing per phase.
      case (p)
        0: begin
          set_lock_regs(typable_code(5), CODE_W'(typable_code(4)), 4'd15);
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          set_lock_regs(typable_code(5), CODE_W'(typable_code(4)),
                        FAIL_W'($urandom_range(14, 2)));
          gap_pct = 73;
          stall_pct = 0;
        end
        2: begin
          set_lock_regs(typable_code(5), '0, 4'd1);
          gap_pct = 0;
          stall_pct = 73;
        end
        default: begin
          set_lock_regs('0, '1, 4'd0);
          gap_pct = 14;
          stall_pct = 14;
        end
      endcase

      counted = 0;
      while (counted < KEYS_PER_PHASE) begin
        case (lk_phase)
          AWAIT_STAR: begin
            // Pick what this session tries; keep failures scarce until the
            // last phase so the open path stays reachable for a while.
            roll = $urandom_range(99);
            if (roll < 15) begin
              goal = GO_NOISE;
              do key = KEY_W'($urandom_range(31)); while (key == KEY_STAR);
            end else begin
              if (roll < 45) goal = GO_MASTER;
              else if (roll < 85 || !(p == 3 || $urandom_range(99) < 8)) goal = GO_USER;
              else if (roll < 93) goal = GO_USER_BAD;
              else goal = GO_RANDOM;
              bad_pos = $urandom_range(4);
              key = KEY_STAR;
            end
          end
          GET_KEYS: begin
            found = 1'b0;
            case (goal)
              GO_MASTER: begin
                want_ch = lk_master[8*(4-lk_index) +: 8];
                found = key_for(want_ch, key);
              end
              GO_USER, GO_USER_BAD: begin
                want_ch = (lk_index < 3'd4) ? lk_stored[8*(3-lk_index) +: 8] : CH_HASH;
                found = key_for(want_ch, key);
              end
              default: ;
            endcase
            if (!found) key = pick_key();
            // Flip one bit of one key to break an otherwise correct entry.
            if (goal == GO_USER_BAD && lk_index == 3'(bad_pos))
              key = key ^ KEY_W'(1 << $urandom_range(KEY_W-1));
          end
          AWAIT_HASH: begin
            key = (goal == GO_MASTER && $urandom_range(3) != 0) ? KEY_HASH : pick_key();
          end
          default: key = pick_key();
        endcase

        // Skip keys the lock simply ignores when counting stimulus.
        if (lk_phase != AWAIT_STAR || key == KEY_STAR) counted++;
        send_key(key, 1'b0, '0);

        // Now and then let the lock run dry before going on.
        if ($urandom_range(399) == 0) drain();
      end
      drain();
    end

    // Let the clock run on so the block can show any stray result.
    repeat (10) @(posedge clk);
    if (lock_replies.size() != 0) begin
      errors += lock_replies.size();
      $display("%0d results never arrived", lock_replies.size());
    end

    $display("Sent %0d keys over four pacing phases and four register sets, %0d results",
             n_keys, n_results);
    $display("Outcomes: %0d opens, %0d new codes, %0d wrong entries, %0d locked; %0d errors",
             n_open, n_new, n_wrong, n_locked, errors);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
